// ===== rtl/page_mode_bitmap_blitter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks used by the blitter top level; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_MODE_BITMAP_BLITTER_UNIT_MACROS_SVH
`define PAGE_MODE_BITMAP_BLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PMBB_ASSERT_SAME(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);
`define PMBB_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define PMBB_ASSERT_SAME(label, clk, rstn, cond, expr, msg)
`define PMBB_ASSERT_NEXT(label, clk, rstn, cond, expr, msg)
`endif

`endif

// ===== rtl/pmbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmbb_pkg
// Shared types and codes of the page-mode bitmap blitter.
// ----------------------------------------------------------------------------
package pmbb_pkg;

    localparam int PAGE_W = 7;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_WR0,
        ST_RD1,
        ST_WR1,
        ST_RQ,
        ST_RDATA
    } blit_state_t;

    typedef struct packed {
        logic              hit0;
        logic              hit1;
        logic [7:0]        col;
        logic [PAGE_W-1:0] page0;
        logic [PAGE_W-1:0] page1;
        logic [7:0]        mask0;
        logic [7:0]        mask1;
    } draw_plan_t;

endpackage

// ===== rtl/pmbb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmbb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pmbb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/pmbb_pixel_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmbb_pixel_map
// Maps one bitmap column onto its two page bytes with clipping masks.
// ----------------------------------------------------------------------------
module pmbb_pixel_map
    import pmbb_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_ROWS    = 64
) (
    input  logic [7:0]  x_base,
    input  logic [7:0]  col_index,
    input  logic [7:0]  y_top,
    input  logic [7:0]  offset_y,
    input  logic [7:0]  column_bits,
    input  logic        invert_pixels,
    output draw_plan_t  plan
);

    localparam int         FULL_PAGES = SCREEN_ROWS / 8;
    localparam int         TAIL_BITS  = SCREEN_ROWS % 8;
    localparam logic [7:0] TAIL_MASK  = 8'((1 << TAIL_BITS) - 1);
    localparam logic [8:0] COLS_LIM   = 9'(SCREEN_COLUMNS);

    function automatic logic [7:0] page_mask(input logic [PAGE_W-1:0] page);
        logic [7:0] m;
        if (32'(page) < FULL_PAGES) begin
            m = 8'hFF;
        end else if (32'(page) == FULL_PAGES) begin
            m = TAIL_MASK;
        end else begin
            m = 8'h00;
        end
        return m;
    endfunction

    logic [7:0]        bits_eff;
    logic [8:0]        col_sum;
    logic [8:0]        row_base;
    logic [15:0]       spread;
    logic              col_ok;
    logic [PAGE_W-1:0] page0;
    logic [PAGE_W-1:0] page1;
    logic [7:0]        mask0;
    logic [7:0]        mask1;

    always_comb begin
        bits_eff = invert_pixels ? ~column_bits : column_bits;
        col_sum  = {1'b0, x_base} + {1'b0, col_index};
        row_base = {1'b0, y_top} + {1'b0, offset_y};
        col_ok   = col_sum < COLS_LIM;
        spread   = {8'h00, bits_eff} << row_base[2:0];
        page0    = PAGE_W'(row_base[8:3]);
        page1    = page0 + PAGE_W'(1);
        mask0    = spread[7:0] & page_mask(page0);
        mask1    = spread[15:8] & page_mask(page1);

        plan.hit0  = col_ok && (mask0 != 8'h00);
        plan.hit1  = col_ok && (mask1 != 8'h00);
        plan.col   = col_sum[7:0];
        plan.page0 = page0;
        plan.page1 = page1;
        plan.mask0 = mask0;
        plan.mask1 = mask1;
    end

endmodule

// ===== rtl/page_mode_bitmap_blitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_mode_bitmap_blitter_unit
// Page-mode monochrome frame store with column draw, clear and byte read.
// ----------------------------------------------------------------------------
// channel  direction  carries
// s_       in         command transaction: kind, draw fields, read address
// m_       out        read_data, one transaction per read command
//
// Draw: the accept, then up to two read-modify-writes on the single RAM port,
// each a read state and a write state that is skipped if nothing is set. Read:
// a request state, then a data state. Clear: one RAM write per byte.
// After reset a clearing pass over all SCREEN_COLUMNS * pages bytes runs with
// s_tready low. A read result stalled on m_tready holds only a later read.
// ----------------------------------------------------------------------------
`include "page_mode_bitmap_blitter_unit_macros.svh"

module page_mode_bitmap_blitter_unit
    import pmbb_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_ROWS    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_base[7:0], col_index[15:8], y_top[23:16], offset_y[31:24],
    // column_bits[39:32], invert_pixels[40], read_addr[50:41], zero fill
    input  logic [55:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata
);

    localparam int PAGE_COUNT = (SCREEN_ROWS + 7) / 8;
    localparam int DEPTH      = SCREEN_COLUMNS * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    blit_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [7:0] x_base_reg;
    logic [7:0] col_index_reg;
    logic [7:0] y_top_reg;
    logic [7:0] offset_y_reg;
    logic [7:0] column_bits_reg;
    logic       invert_reg;
    logic [9:0] read_addr_reg;

    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    draw_plan_t        plan;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;
    logic              out_free;
    logic              accept;
    logic              load_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    pmbb_pixel_map #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_pixel_map (
        .x_base       (x_base_reg),
        .col_index    (col_index_reg),
        .y_top        (y_top_reg),
        .offset_y     (offset_y_reg),
        .column_bits  (column_bits_reg),
        .invert_pixels(invert_reg),
        .plan         (plan)
    );

    pmbb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign addr0 = ADDR_W'(plan.col) + ADDR_W'(32'(plan.page0) * SCREEN_COLUMNS);
    assign addr1 = ADDR_W'(plan.col) + ADDR_W'(32'(plan.page1) * SCREEN_COLUMNS);
    assign rd_addr     = ADDR_W'(read_addr_reg);
    assign rd_in_range = 32'(read_addr_reg) < DEPTH;
    assign out_free    = !m_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_tready     = 1'b0;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = '0;
        ram_wdata    = 8'h00;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_ADDR) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_DRAW:  state_next = ST_RD0;
                        KIND_READ:  state_next = ST_RQ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD0: begin
                ram_addr   = addr0;
                state_next = plan.hit0 ? ST_WR0 : ST_RD1;
            end
            ST_WR0: begin
                ram_we     = 1'b1;
                ram_addr   = addr0;
                ram_wdata  = ram_rdata | plan.mask0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                ram_addr   = addr1;
                state_next = plan.hit1 ? ST_WR1 : ST_IDLE;
            end
            ST_WR1: begin
                ram_we     = 1'b1;
                ram_addr   = addr1;
                ram_wdata  = ram_rdata | plan.mask1;
                state_next = ST_IDLE;
            end
            ST_RQ: begin
                ram_addr = rd_addr;
                if (out_free) begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA: begin
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_base_reg      <= s_tdata[7:0];
            col_index_reg   <= s_tdata[15:8];
            y_top_reg       <= s_tdata[23:16];
            offset_y_reg    <= s_tdata[31:24];
            column_bits_reg <= s_tdata[39:32];
            invert_reg      <= s_tdata[40];
            read_addr_reg   <= s_tdata[50:41];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= rd_in_range ? ram_rdata : 8'h00;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PMBB_ASSERT_SAME(a_no_write_idle, aclk, aresetn, state_reg == ST_IDLE, !ram_we, "store written while idle")
    `PMBB_ASSERT_SAME(a_slot_free, aclk, aresetn, state_reg == ST_RDATA, !m_valid_reg, "result slot busy at load")
    `PMBB_ASSERT_NEXT(a_read_issue, aclk, aresetn, accept && s_tuser == KIND_READ, state_reg == ST_RQ, "read command not issued")
    `PMBB_ASSERT_NEXT(a_draw_end, aclk, aresetn, state_reg == ST_WR1, state_reg == ST_IDLE && !m_tvalid || state_reg == ST_IDLE, "draw did not finish")

endmodule
